@@ rtl/core/ptc_pkg.sv @@
package ptc_pkg;

  localparam int unsigned BUFFER_DEPTH = 1024;
  localparam int unsigned IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int unsigned CNT_W        = IDX_W + 1;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned PAT_W        = 24;
  localparam int unsigned CFG_DATA_W   = 32;

  // depth must stay a power of two so the pointers wrap on their own
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    CFG_CAPTURE_LENGTH  = 1'b0,
    CFG_TRIGGER_PATTERN = 1'b1
  } cfg_reg_e;

  // one classified item as it travels from the front to the back
  typedef struct packed {
    logic              is_clear;
    logic              match;
    logic [WORD_W-1:0] word;
  } entry_t;

endpackage

@@ rtl/core/ptc_front.sv @@
module ptc_front (
  input  logic                          action_i,
  input  logic [ptc_pkg::WORD_W-1:0]    sample_word_i,
  input  logic [ptc_pkg::PAT_W-1:0]     pattern_i,
  output ptc_pkg::entry_t               entry_o
);

  always_comb begin
    entry_o.is_clear = action_i;
    // compare the low bits only; the top byte of the word never takes part
    entry_o.match    = (sample_word_i[ptc_pkg::PAT_W-1:0] == pattern_i);
    entry_o.word     = sample_word_i;
  end

endmodule

@@ rtl/core/ptc_queue.sv @@
module ptc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ptc_pkg::entry_t push_data_i,
  output logic            full_o,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output ptc_pkg::entry_t pop_data_o
);

  ptc_pkg::entry_t                 mem_q [ptc_pkg::QUEUE_DEPTH];
  logic [ptc_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [ptc_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [ptc_pkg::QCNT_W-1:0]      count_q, count_d;
  logic                            do_push, do_pop;

  assign full_o      = (count_q == ptc_pkg::QCNT_W'(ptc_pkg::QUEUE_DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ptc_pkg::QCNT_W'(ptc_pkg::QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |=> (count_q <= ptc_pkg::QCNT_W'(1)))
    else $error("queue grew by more than one item");

endmodule

@@ rtl/core/ptc_back.sv @@
module ptc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ptc_pkg::CNT_W-1:0]   capture_length_i,
  input  logic                        entry_valid_i,
  input  ptc_pkg::entry_t             entry_i,
  output logic                        entry_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        write_enable_o,
  output logic [ptc_pkg::IDX_W-1:0]   write_index_o,
  output logic [ptc_pkg::WORD_W-1:0]  write_data_o,
  output logic                        triggered_o,
  output logic                        capture_done_o,
  output logic [ptc_pkg::CNT_W-1:0]   captured_count_o
);

  logic                       armed_q, armed_d;
  logic                       done_q, done_d;
  logic [ptc_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       valid_q, valid_d;
  logic                       we_q, we_d;
  logic [ptc_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [ptc_pkg::WORD_W-1:0] data_q, data_d;
  logic [ptc_pkg::CNT_W-1:0]  len_eff;
  logic                       take;

  // saturate the length to the buffer depth
  assign len_eff = (capture_length_i > ptc_pkg::CNT_W'(ptc_pkg::BUFFER_DEPTH))
                   ? ptc_pkg::CNT_W'(ptc_pkg::BUFFER_DEPTH) : capture_length_i;

  // advance whenever the output register is empty or being drained
  assign take        = entry_valid_i && (!valid_q || !out_stall_i);
  assign entry_pop_o = take;

  always_comb begin
    armed_d = armed_q;
    done_d  = done_q;
    count_d = count_q;
    valid_d = valid_q && out_stall_i;
    we_d    = we_q;
    idx_d   = idx_q;
    data_d  = data_q;
    if (take) begin
      valid_d = 1'b1;
      we_d    = 1'b0;
      idx_d   = '0;
      data_d  = '0;
      if (entry_i.is_clear) begin
        armed_d = 1'b0;
        done_d  = 1'b0;
        count_d = '0;
      end else if (!done_q) begin
        if (!armed_q && (count_q < len_eff) && entry_i.match) begin
          armed_d = 1'b1;
        end
        if (armed_d && (count_q < len_eff)) begin
          we_d    = 1'b1;
          idx_d   = count_q[ptc_pkg::IDX_W-1:0];
          data_d  = entry_i.word;
          count_d = count_q + 1'b1;
        end
        if (count_d >= len_eff) begin
          done_d  = 1'b1;
          armed_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      armed_q <= armed_d;
      done_q  <= done_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    we_q   <= we_d;
    idx_q  <= idx_d;
    data_q <= data_d;
  end

  assign out_valid_o      = valid_q;
  assign write_enable_o   = we_q;
  assign write_index_o    = idx_q;
  assign write_data_o     = data_q;
  assign triggered_o      = armed_q;
  assign capture_done_o   = done_q;
  assign captured_count_o = count_q;

  a_done_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !armed_q)
    else $error("trigger still armed after capture done");

  a_index_follows_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && we_q) |-> (count_q == ({1'b0, idx_q} + 1'b1)))
    else $error("stored index out of step with count");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !we_q) |-> (idx_q == '0 && data_q == '0))
    else $error("index or data set without a store");

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ptc_pkg::CNT_W'(ptc_pkg::BUFFER_DEPTH))
    else $error("count beyond buffer depth");

endmodule

@@ rtl/core/pattern_triggered_capture_unit.sv @@
// Pattern-triggered capture: watches a stream of 32-bit words and, once a word
// whose low 24 bits equal the trigger pattern arrives, hands that word and the
// ones after it out with consecutive buffer indices until the configured
// length (saturated to the buffer depth) is reached; a clear item restarts it.
// One item is taken every clock cycle unless the queue is full; each gives exactly one
// result item, passing through the two-entry queue and then the output register
// of the capture stage. Stalling the output fills the queue, then stalls input.
module pattern_triggered_capture_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  ptc_pkg::cfg_reg_e                cfg_index_i,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic [ptc_pkg::WORD_W-1:0]       sample_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             write_enable_o,
  output logic [ptc_pkg::IDX_W-1:0]        write_index_o,
  output logic [ptc_pkg::WORD_W-1:0]       write_data_o,
  output logic                             triggered_o,
  output logic                             capture_done_o,
  output logic [ptc_pkg::CNT_W-1:0]        captured_count_o
);

  logic [ptc_pkg::CNT_W-1:0] cap_len_q, cap_len_d;
  logic [ptc_pkg::PAT_W-1:0] pattern_q, pattern_d;
  ptc_pkg::entry_t           front_entry;
  ptc_pkg::entry_t           back_entry;
  logic                      q_full, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cap_len_d = cap_len_q;
    pattern_d = pattern_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        ptc_pkg::CFG_CAPTURE_LENGTH:  cap_len_d = cfg_data_i[ptc_pkg::CNT_W-1:0];
        ptc_pkg::CFG_TRIGGER_PATTERN: pattern_d = cfg_data_i[ptc_pkg::PAT_W-1:0];
        default: begin
          cap_len_d = cap_len_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_len_q <= '0;
      pattern_q <= '0;
    end else begin
      cap_len_q <= cap_len_d;
      pattern_q <= pattern_d;
    end
  end

  ptc_front u_front (
    .action_i      (action_i),
    .sample_word_i (sample_word_i),
    .pattern_i     (pattern_q),
    .entry_o       (front_entry)
  );

  assign in_stall_o = q_full;

  ptc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_entry),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (back_entry)
  );

  ptc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .capture_length_i (cap_len_q),
    .entry_valid_i    (q_valid),
    .entry_i          (back_entry),
    .entry_pop_o      (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .write_enable_o   (write_enable_o),
    .write_index_o    (write_index_o),
    .write_data_o     (write_data_o),
    .triggered_o      (triggered_o),
    .capture_done_o   (capture_done_o),
    .captured_count_o (captured_count_o)
  );

endmodule
